/* rtl/hashed_inverted_frame_table_top_assert.svh */
// Assertion macros for the frame table checker.
// Used by hift_chk.sv; expects clk and rst_n in scope.
`ifndef HASHED_INVERTED_FRAME_TABLE_TOP_ASSERT_SVH
`define HASHED_INVERTED_FRAME_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HIFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HIFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hift_pkg.sv */
// Shared types and constants of the hashed inverted frame table.
// No dependencies.
`timescale 1ns / 1ps

package hift_pkg;

  localparam int FC_W    = 11;   // frame_count register
  localparam int PID_W   = 16;
  localparam int PAGE_W  = 16;
  localparam int KIND_W  = 2;
  localparam int REQ_W   = 2;
  localparam int STS_W   = 2;
  localparam int FRAME_W = 10;   // frame field of a result beat

  localparam logic [FC_W-1:0] FC_RESET = 11'd1024;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd3;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_FAIL    = 2'd1;
  localparam logic [STS_W-1:0] STS_REMOVED = 2'd2;

  // n/100 and n/18 by reciprocal multiply; exact for n < 2048
  localparam int R100_W = 11;
  localparam int R18_W  = 12;
  localparam logic [R100_W-1:0] R100 = 11'd1311;  // ceil(2^17/100)
  localparam logic [R18_W-1:0]  R18  = 12'd3641;  // ceil(2^16/18)
  localparam int SH100  = 17;
  localparam int SH18   = 16;
  localparam int Q100_W = 5;     // n/100 <= 20
  localparam int Q18_W  = 7;     // n/18 <= 113
  localparam int SUM_W  = 24;    // 4*q100 + pid*q18 + page

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PID_W-1:0]  proc_id;
    logic [PAGE_W-1:0] page_num;
    logic [KIND_W-1:0] page_kind;
  } hift_in_beat_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [FC_W-1:0]    page_count;
    logic [FRAME_W-1:0] frame;
  } hift_out_beat_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  owner;
    logic [PAGE_W-1:0] page;
  } hift_entry_t;

endpackage

/* rtl/hift_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hift_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hift_hash.sv */
// Start-frame hash: three-stage pipeline, (n/100)*4 + pid*(n/18) + page,
// clamped to n-1. Depends on hift_pkg.
`timescale 1ns / 1ps

module hift_hash #(
  parameter int FRAMES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [hift_pkg::FC_W-1:0]           n,
  input  logic [hift_pkg::PID_W-1:0]          pid,
  input  logic [hift_pkg::PAGE_W-1:0]         page,
  output logic                                done,
  output logic [$clog2(FRAMES)-1:0]           frame
);

  import hift_pkg::*;

  localparam int FW = $clog2(FRAMES);

  logic                      v1_r, v2_r, v3_r;
  logic [Q100_W-1:0]         q100_r;
  logic [Q18_W-1:0]          q18_r;
  logic [SUM_W-1:0]          sum_r;
  logic [FW-1:0]             frame_r;
  logic [FC_W+R100_W-1:0]    p100;
  logic [FC_W+R18_W-1:0]     p18;
  logic [PID_W+Q18_W-1:0]    pq;
  logic [SUM_W-1:0]          sum_nxt;
  logic [FW-1:0]             frame_nxt;

  always_comb begin
    p100      = n * R100;
    p18       = n * R18;
    pq        = pid * q18_r;
    sum_nxt   = (SUM_W'(q100_r) << 2) + SUM_W'(pq) + SUM_W'(page);
    if (sum_r >= SUM_W'(n)) begin
      frame_nxt = FW'(n - FC_W'(1));
    end else begin
      frame_nxt = FW'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    q100_r  <= p100[SH100 +: Q100_W];
    q18_r   <= p18[SH18 +: Q18_W];
    sum_r   <= sum_nxt;
    frame_r <= frame_nxt;
  end

  assign done  = v3_r;
  assign frame = frame_r;

endmodule

/* rtl/hift_ctrl.sv */
// Sequencer: clearing pass, probe and scan over the entry RAM with
// read-check-write, result hold. Depends on hift_pkg.
`timescale 1ns / 1ps

module hift_ctrl #(
  parameter int FRAMES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  hift_pkg::hift_in_beat_t         req,
  input  logic [hift_pkg::FC_W-1:0]       n,
  output logic                            idle,
  output logic                            hash_go,
  output logic [hift_pkg::FC_W-1:0]       hash_n,
  output logic [hift_pkg::PID_W-1:0]      hash_pid,
  output logic [hift_pkg::PAGE_W-1:0]     hash_page,
  input  logic                            hash_done,
  input  logic [$clog2(FRAMES)-1:0]       hash_frame,
  output logic                            ram_we,
  output logic [$clog2(FRAMES)-1:0]       ram_waddr,
  output hift_pkg::hift_entry_t           ram_wdata,
  output logic [$clog2(FRAMES)-1:0]       ram_raddr,
  input  hift_pkg::hift_entry_t           ram_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output hift_pkg::hift_out_beat_t        res
);

  import hift_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int IW = FW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HGO   = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [REQ_W-1:0]  op_r, op_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [FC_W-1:0]   n_r, n_nxt;
  logic [FW-1:0]     iss_idx_r, iss_idx_nxt;
  logic [FC_W-1:0]   iss_rem_r, iss_rem_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [FW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              chk_last_r, chk_last_nxt;
  logic [FC_W-1:0]   cnt_r, cnt_nxt;
  logic [FW-1:0]     clr_idx_r, clr_idx_nxt;
  hift_out_beat_t    res_r, res_nxt;

  logic              issue;
  logic              own;
  logic              hit;
  logic [IW-1:0]     inc;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    page_nxt     = page_r;
    kind_nxt     = kind_r;
    n_nxt        = n_r;
    iss_idx_nxt  = iss_idx_r;
    iss_rem_nxt  = iss_rem_r;
    cnt_nxt      = cnt_r;
    clr_idx_nxt  = clr_idx_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_r;
    ram_wdata    = '0;
    hit          = 1'b0;

    // issue side: one read per cycle along the probe sequence
    issue        = (state_r == S_SCAN) && (iss_rem_r != '0);
    inc          = {1'b0, iss_idx_r} + IW'(1);
    chk_v_nxt    = issue;
    chk_idx_nxt  = iss_idx_r;
    chk_last_nxt = (iss_rem_r == FC_W'(1));
    if (issue) begin
      iss_idx_nxt = (inc == IW'(n_r)) ? '0 : inc[FW-1:0];
      iss_rem_nxt = iss_rem_r - FC_W'(1);
    end

    own = ram_rdata.valid && (ram_rdata.owner == pid_r);

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + FW'(1);
        if (clr_idx_r == FW'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (req_valid) begin
          op_nxt   = req.req_type;
          pid_nxt  = req.proc_id;
          page_nxt = req.page_num;
          kind_nxt = req.page_kind;
          n_nxt    = n;
          if (req.req_type inside {REQ_ALLOC, REQ_FREE}) begin
            state_nxt = S_HGO;
          end else begin
            iss_idx_nxt = '0;
            iss_rem_nxt = n;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_HGO: begin
        state_nxt = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          iss_idx_nxt = hash_frame;
          iss_rem_nxt = n_r;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_v_r) begin
          case (op_r)
            REQ_ALLOC: begin
              if (!ram_rdata.valid) begin
                ram_we    = 1'b1;
                ram_wdata = '{valid: 1'b1, kind: kind_r, owner: pid_r, page: page_r};
                hit       = 1'b1;
              end
            end
            REQ_FREE: begin
              if (own && (ram_rdata.page == page_r)) begin
                ram_we = 1'b1;
                hit    = 1'b1;
              end
            end
            REQ_COUNT: begin
              if (own) begin
                cnt_nxt = cnt_r + FC_W'(1);
              end
            end
            default: begin
              if (own) begin
                ram_we = 1'b1;
              end
            end
          endcase
          if (hit) begin
            res_nxt   = '{status: STS_OK, page_count: '0, frame: FRAME_W'(chk_idx_r)};
            state_nxt = S_DONE;
          end else if (chk_last_r) begin
            case (op_r)
              REQ_COUNT: res_nxt = '{status: STS_OK, page_count: cnt_nxt, frame: '0};
              REQ_REMOVE: res_nxt = '{status: STS_REMOVED, page_count: '0, frame: '0};
              default: res_nxt = '{status: STS_FAIL, page_count: '0, frame: '0};
            endcase
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      chk_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      chk_v_r   <= chk_v_nxt;
    end
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    page_r     <= page_nxt;
    kind_r     <= kind_nxt;
    n_r        <= n_nxt;
    iss_idx_r  <= iss_idx_nxt;
    iss_rem_r  <= iss_rem_nxt;
    chk_idx_r  <= chk_idx_nxt;
    chk_last_r <= chk_last_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign hash_go   = (state_r == S_HGO);
  assign hash_n    = n_r;
  assign hash_pid  = pid_r;
  assign hash_page = page_r;
  assign ram_raddr = iss_idx_r;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

/* rtl/hashed_inverted_frame_table_top.sv */
// Top level of the hashed inverted frame table: ports, frame_count register,
// result register. Depends on hift_pkg, hift_ram, hift_hash, hift_ctrl.
`timescale 1ns / 1ps

//  channel | handshake            | beat
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | hift_in_beat_t: req_type, proc_id, page_num, page_kind
//  out     | out_valid / out_ready| hift_out_beat_t: status, page_count, frame
//  cfg     | cfg_valid / cfg_ready| cfg_data: frame_count (11 bits)
//
//  One request at a time. Allocate/free run the hash pipeline, then up to n probe
//  steps with one entry RAM read each; count/remove read all n entries,
//  n = frame_count clamped to 1..FRAMES. All scans share the single RAM read port.
//  After reset a clearing pass writes every entry empty, with in_ready low;
//  cfg is always ready. A stalled out beat holds in the result register while
//  the next request is taken; that request then waits to finish.

module hashed_inverted_frame_table_top #(
  parameter int FRAMES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hift_pkg::hift_in_beat_t     in_beat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hift_pkg::hift_out_beat_t    out_beat,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hift_pkg::FC_W-1:0]   cfg_data
);

  import hift_pkg::*;

  localparam int FW     = $clog2(FRAMES);
  localparam int ENTRYW = $bits(hift_entry_t);

  logic [FC_W-1:0]  frame_count_r;
  logic [FC_W-1:0]  n_eff;
  logic             out_valid_r;
  hift_out_beat_t   out_beat_r;

  logic             ctrl_idle;
  logic             hash_go, hash_done;
  logic [FC_W-1:0]  hash_n;
  logic [PID_W-1:0] hash_pid;
  logic [PAGE_W-1:0] hash_page;
  logic [FW-1:0]    hash_frame;
  logic             ram_we;
  logic [FW-1:0]    ram_waddr, ram_raddr;
  hift_entry_t      ram_wdata, ram_rdata;
  logic             res_valid, res_ready;
  hift_out_beat_t   res;
  logic             in_acc;

  // frames in use: zero acts as one, beyond the table acts as the table size
  always_comb begin
    if (frame_count_r == '0) begin
      n_eff = FC_W'(1);
    end else if (32'(frame_count_r) > FRAMES) begin
      n_eff = FC_W'(FRAMES);
    end else begin
      n_eff = frame_count_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl_idle;
  assign in_acc    = in_valid && in_ready;

  // result register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_count_r <= cfg_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
    if (res_ready && res_valid) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  hift_ram #(
    .WIDTH (ENTRYW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hift_hash #(
    .FRAMES (FRAMES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (hash_go),
    .n     (hash_n),
    .pid   (hash_pid),
    .page  (hash_page),
    .done  (hash_done),
    .frame (hash_frame)
  );

  hift_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_acc),
    .req        (in_beat),
    .n          (n_eff),
    .idle       (ctrl_idle),
    .hash_go    (hash_go),
    .hash_n     (hash_n),
    .hash_pid   (hash_pid),
    .hash_page  (hash_page),
    .hash_done  (hash_done),
    .hash_frame (hash_frame),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

/* rtl/hift_chk.sv */
// Port-level checker for the frame table, bound to the top level.
// Depends on hift_pkg and hashed_inverted_frame_table_top_assert.svh.
`timescale 1ns / 1ps
`include "hashed_inverted_frame_table_top_assert.svh"

module hift_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input hift_pkg::hift_out_beat_t out_beat
);

  import hift_pkg::*;

  // stalled result beat holds
  `HIFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat), "out beat changed while stalled")

  // one request in flight: ready drops right after a beat is taken
  `HIFT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "in_ready held after accept")

  // remove results carry no count and no frame
  `HIFT_ASSERT_NOW(a_remove_clean, out_valid && (out_beat.status == STS_REMOVED), (out_beat.page_count == '0) && (out_beat.frame == '0), "remove result not clean")

  // failed probes report frame zero
  `HIFT_ASSERT_NOW(a_fail_clean, out_valid && (out_beat.status == STS_FAIL), (out_beat.frame == '0) && (out_beat.page_count == '0), "failed result not clean")

endmodule

bind hashed_inverted_frame_table_top hift_chk u_hift_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
